@@ hdl/bsrf_pkg.sv @@
// bsrf_pkg: shared constants, request codes and types for the bitmap set register file
// no dependencies
`default_nettype none
package bsrf_pkg;

    localparam int NUM_SETS = 6;
    localparam int UNIVERSE = 64;

    localparam int REQ_W    = 3;
    localparam int IDX_W    = 3;
    localparam int ELEM_W   = 8;
    localparam int MEMBER_W = 6;

    localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int UNIV_W = $clog2(UNIVERSE);

    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNION     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INTERSECT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DIFF      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LIST      = 3'd5;

    typedef logic [UNIVERSE-1:0] t_set;

    typedef struct packed {
        logic                emit;
        logic [MEMBER_W-1:0] member;
        logic                last;
        logic                done;
    } t_list_out;

    function automatic logic [SET_AW-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
        return SET_AW'(idx);
    endfunction

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return (32'(idx) < NUM_SETS);
    endfunction

endpackage
`default_nettype wire

@@ hdl/bsrf_ram.sv @@
// bsrf_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module bsrf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 6
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ hdl/bsrf_lister.sv @@
// bsrf_lister: walks a loaded set one bit per cycle and emits its members in ascending order
// depends on bsrf_pkg
`default_nettype none
module bsrf_lister (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire bsrf_pkg::t_set  i_bits,
    output bsrf_pkg::t_list_out  o_list
);

    logic                          r_act;
    bsrf_pkg::t_set                r_bits;
    logic [bsrf_pkg::UNIV_W-1:0]   r_idx;
    logic                          rest_zero;

    // nothing left above the current bit
    assign rest_zero = (r_bits[bsrf_pkg::UNIVERSE-1:1] == '0);

    always_comb begin
        o_list.emit   = r_act & r_bits[0];
        o_list.member = bsrf_pkg::MEMBER_W'(r_idx);
        o_list.last   = r_act & r_bits[0] & rest_zero;
        o_list.done   = r_act & rest_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_load) begin
            r_act <= 1'b1;
        end else if (r_act && rest_zero) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bits <= i_bits;
            r_idx  <= '0;
        end else if (r_act) begin
            r_bits <= r_bits >> 1;
            r_idx  <= r_idx + 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ hdl/bitmap_set_register_file_core.sv @@
// bitmap_set_register_file_core: top level of the bitmap set register file
// depends on bsrf_pkg, bsrf_ram and bsrf_lister
//
// usage
//   a request word is taken at a clock edge where i_start is high and o_busy is low
//   request fields: i_req_type, i_set_a, i_set_b, i_set_dest, i_element
//   results leave on o_status, o_member, o_is_empty, o_last, each for exactly one
//   cycle while o_valid is high; the receiver cannot stall, so no result ever waits
//   clear, insert, union, intersect, difference and unknown codes give one result
//   word, registered after the execute state; o_busy is high for one cycle
//   list walks the set one bit per cycle through the lister: the execute state loads
//   the lister, each member found is registered as a result word, and the block is
//   busy until the walk reaches the highest member (one result for an empty set)
//   the sets live in two copies of a small ram (one read port each, so set a and
//   set b are read in the same cycle); every write goes to both copies
//   one request at a time: read in the accept cycle, modify and write back in the
//   next, so accesses to one entry never overlap
//   reset (i_rst_n low, synchronous) drops per-set valid bits so every set reads as
//   empty without a clearing pass; ram contents themselves are not touched
`default_nettype none
module bitmap_set_register_file_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic [bsrf_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [bsrf_pkg::IDX_W-1:0]     i_set_a,
    input  wire logic [bsrf_pkg::IDX_W-1:0]     i_set_b,
    input  wire logic [bsrf_pkg::IDX_W-1:0]     i_set_dest,
    input  wire logic [bsrf_pkg::ELEM_W-1:0]    i_element,
    output logic                                o_valid,
    output logic                                o_status,
    output logic      [bsrf_pkg::MEMBER_W-1:0]  o_member,
    output logic                                o_is_empty,
    output logic                                o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LIST = 2'd2;

    logic [1:0] r_state, n_state;

    // latched request
    logic [bsrf_pkg::REQ_W-1:0]  r_req_type;
    logic [bsrf_pkg::IDX_W-1:0]  r_set_a;
    logic [bsrf_pkg::IDX_W-1:0]  r_set_dest;
    logic [bsrf_pkg::ELEM_W-1:0] r_element;

    // per-set valid: an entry never written since reset reads as empty
    logic [bsrf_pkg::NUM_SETS-1:0] r_valid;

    logic                          accept;
    logic [bsrf_pkg::SET_AW-1:0]   rd_addr_a, rd_addr_b;
    bsrf_pkg::t_set                rdata_a, rdata_b;
    logic                          r_a_ok, r_b_ok;
    logic [bsrf_pkg::SET_AW-1:0]   r_addr_a, r_addr_b;
    bsrf_pkg::t_set                va, vb;

    logic                          wr_en;
    logic [bsrf_pkg::IDX_W-1:0]    wr_idx;
    bsrf_pkg::t_set                wr_data;
    logic                          we;
    logic [bsrf_pkg::SET_AW-1:0]   wr_addr;
    logic                          elem_ok;

    logic                          list_load;
    bsrf_pkg::t_list_out           list_out;

    logic                          r_out_vld, n_out_vld;
    logic                          r_out_status, n_out_status;
    logic [bsrf_pkg::MEMBER_W-1:0] r_out_member, n_out_member;
    logic                          r_out_empty, n_out_empty;
    logic                          r_out_last, n_out_last;

    assign o_busy = (r_state != ST_IDLE);
    assign accept = i_start && !o_busy;

    // read both operands in the accept cycle
    assign rd_addr_a = bsrf_pkg::idx_to_addr(i_set_a);
    assign rd_addr_b = bsrf_pkg::idx_to_addr(i_set_b);

    bsrf_ram #(
        .WIDTH (bsrf_pkg::UNIVERSE),
        .DEPTH (bsrf_pkg::NUM_SETS)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr_a),
        .o_rdata (rdata_a)
    );

    bsrf_ram #(
        .WIDTH (bsrf_pkg::UNIVERSE),
        .DEPTH (bsrf_pkg::NUM_SETS)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr_b),
        .o_rdata (rdata_b)
    );

    bsrf_lister u_lister (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (list_load),
        .i_bits  (va),
        .o_list  (list_out)
    );

    // request capture, payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req_type;
            r_set_a    <= i_set_a;
            r_set_dest <= i_set_dest;
            r_element  <= i_element;
            r_a_ok     <= bsrf_pkg::idx_in_range(i_set_a);
            r_b_ok     <= bsrf_pkg::idx_in_range(i_set_b);
            r_addr_a   <= rd_addr_a;
            r_addr_b   <= rd_addr_b;
        end
    end

    // operands: out-of-range index or never-written entry reads as empty
    always_comb begin
        va = (r_a_ok && r_valid[r_addr_a]) ? rdata_a : '0;
        vb = (r_b_ok && r_valid[r_addr_b]) ? rdata_b : '0;
    end

    assign elem_ok = (32'(r_element) < bsrf_pkg::UNIVERSE);

    // modify step
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_set_dest;
        wr_data = '0;
        case (r_req_type)
            bsrf_pkg::REQ_CLEAR: begin
                wr_en  = 1'b1;
                wr_idx = r_set_a;
            end
            bsrf_pkg::REQ_INSERT: begin
                wr_en   = elem_ok;
                wr_idx  = r_set_a;
                wr_data = va | (bsrf_pkg::UNIVERSE'(1) << r_element[bsrf_pkg::UNIV_W-1:0]);
            end
            bsrf_pkg::REQ_UNION:     begin
                wr_en   = 1'b1;
                wr_data = va | vb;
            end
            bsrf_pkg::REQ_INTERSECT: begin
                wr_en   = 1'b1;
                wr_data = va & vb;
            end
            bsrf_pkg::REQ_DIFF:      begin
                wr_en   = 1'b1;
                wr_data = va & ~vb;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // write back only in the execute cycle and only to a real set
    assign we      = (r_state == ST_EXEC) && wr_en && bsrf_pkg::idx_in_range(wr_idx);
    assign wr_addr = bsrf_pkg::idx_to_addr(wr_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // nonempty list hands the set to the lister
    assign list_load = (r_state == ST_EXEC) && (r_req_type == bsrf_pkg::REQ_LIST) && (va != '0);

    // sequencer and result word
    always_comb begin
        n_state      = r_state;
        n_out_vld    = 1'b0;
        n_out_status = 1'b0;
        n_out_member = '0;
        n_out_empty  = 1'b0;
        n_out_last   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (list_load) begin
                    n_state = ST_LIST;
                end else begin
                    n_state    = ST_IDLE;
                    n_out_vld  = 1'b1;
                    n_out_last = 1'b1;
                    if (r_req_type == bsrf_pkg::REQ_INSERT) begin
                        n_out_status = !elem_ok;
                    end
                    if (r_req_type == bsrf_pkg::REQ_LIST) begin
                        n_out_empty = 1'b1;
                    end
                end
            end
            ST_LIST: begin
                n_out_vld    = list_out.emit;
                n_out_member = list_out.member;
                n_out_last   = list_out.last;
                if (list_out.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_member <= n_out_member;
        r_out_empty  <= n_out_empty;
        r_out_last   <= n_out_last;
    end

    assign o_valid    = r_out_vld;
    assign o_status   = r_out_status;
    assign o_member   = r_out_member;
    assign o_is_empty = r_out_empty;
    assign o_last     = r_out_last;

endmodule
`default_nettype wire
